// ===== hdl/generational_handle_allocator_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GHA_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("gha assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GHA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gha assertion failed");

`endif

// ===== hdl/gha_pkg.sv =====
package gha_pkg;

  // Field widths of the request and response transfers and of the limit register.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIMIT_W  = 11;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  // Index value that marks a dead handle.
  localparam logic [HALF_W-1:0] DEAD_INDEX = '1;

  // Reset value of the entity limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

endpackage

// ===== hdl/gha_req_if.sv =====
interface gha_req_if;
  import gha_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HALF_W-1:0]   handle_index;
  logic [HALF_W-1:0]   handle_version;

  modport source (output valid, output mode, output handle_index, output handle_version,
                  input ready);
  modport sink   (input valid, input mode, input handle_index, input handle_version,
                  output ready);
endinterface

// ===== hdl/gha_rsp_if.sv =====
interface gha_rsp_if;
  import gha_pkg::*;

  logic                valid;
  logic                ready;
  logic [HALF_W-1:0]   new_index;
  logic [HALF_W-1:0]   new_version;
  logic [STATUS_W-1:0] status;
  logic                is_valid;

  modport source (output valid, output new_index, output new_version, output status,
                  output is_valid, input ready);
  modport sink   (input valid, input new_index, input new_version, input status,
                  input is_valid, output ready);
endinterface

// ===== hdl/gha_ram.sv =====
module gha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/generational_handle_allocator.sv =====
// Generational handle allocator. When a request is accepted, a destroy reads
// the slot-state memory and a create the free-stack memory (each has one
// registered read port). In the execute state, once the response register
// is empty or being taken, the entry is updated, the counters move and the
// response register is loaded. One request is in flight at a time; a new
// request is accepted while the last response still waits in its register,
// and a held response stalls only the following request. The freed slot
// keeps its next version in the free stack next to its index, so a create
// that reuses a slot reads one memory only. Slots are handed out in order
// under a fill count, so no memory is cleared after reset and the block is
// ready as soon as reset is released.
module generational_handle_allocator #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [gha_pkg::LIMIT_W-1:0] cfg_wdata_i,
  gha_req_if.sink                req_i,
  gha_rsp_if.source              rsp_o
);
  import gha_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned FW = IW + HALF_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state_q, state_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic [CW-1:0]       free_count_q, free_count_d;
  logic [CW-1:0]       slots_used_q, slots_used_d;
  logic [MODE_W-1:0]   mode_q;
  logic [HALF_W-1:0]   idx_q;
  logic [HALF_W-1:0]   ver_q;

  logic                rsp_valid_q, rsp_valid_d;
  logic [HALF_W-1:0]   rsp_index_q, rsp_index_d;
  logic [HALF_W-1:0]   rsp_version_q, rsp_version_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic                rsp_is_valid_q, rsp_is_valid_d;

  logic                accept;
  logic                exec_go;
  logic [CW-1:0]       top_count;

  logic                live_we, live_wdata, live_rdata;
  logic [IW-1:0]       live_waddr;
  logic                stack_we, stack_re;
  logic [FW-1:0]       stack_wdata, stack_rdata;

  logic                has_free, can_fresh, in_range, destroy_ok;

  assign accept    = req_i.valid && req_i.ready;
  assign exec_go   = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign top_count = free_count_q - CW'(1);

  assign req_i.ready = (state_q == ST_IDLE);

  // Per-slot live flag, read at accept for a destroy.
  gha_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (live_waddr),
    .wdata_i (live_wdata),
    .re_i    (accept && (req_i.mode == MODE_DESTROY)),
    .raddr_i (req_i.handle_index[IW-1:0]),
    .rdata_o (live_rdata)
  );

  // Free stack of {next version, slot index}, top entry read at accept for a create.
  assign stack_re = accept && (req_i.mode == MODE_CREATE);

  gha_ram #(.WIDTH(FW), .DEPTH(CAPACITY)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (free_count_q[IW-1:0]),
    .wdata_i (stack_wdata),
    .re_i    (stack_re),
    .raddr_i (top_count[IW-1:0]),
    .rdata_o (stack_rdata)
  );

  // Decisions taken in the execute cycle from the read data and the counters.
  assign has_free   = (free_count_q != '0);
  assign can_fresh  = (LW'(slots_used_q) < LW'(limit_q)) && (slots_used_q < CW'(CAPACITY));
  assign in_range   = (idx_q < HALF_W'(slots_used_q));
  assign destroy_ok = in_range && live_rdata && (free_count_q < CW'(CAPACITY));

  // Write-back, counter update and response formation.
  always_comb begin
    state_d        = state_q;
    free_count_d   = free_count_q;
    slots_used_d   = slots_used_q;
    live_we        = 1'b0;
    live_waddr     = idx_q[IW-1:0];
    live_wdata     = 1'b0;
    stack_we       = 1'b0;
    stack_wdata    = {ver_q + HALF_W'(1), idx_q[IW-1:0]};
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    rsp_index_d    = rsp_index_q;
    rsp_version_d  = rsp_version_q;
    rsp_status_d   = rsp_status_q;
    rsp_is_valid_d = rsp_is_valid_q;

    if (accept) begin
      state_d = ST_EXEC;
    end

    if (exec_go) begin
      state_d        = ST_IDLE;
      rsp_valid_d    = 1'b1;
      rsp_index_d    = '0;
      rsp_version_d  = '0;
      rsp_status_d   = STATUS_OK;
      rsp_is_valid_d = 1'b0;
      case (mode_q)
        MODE_CREATE: begin
          if (has_free) begin
            free_count_d  = top_count;
            live_we       = 1'b1;
            live_waddr    = stack_rdata[IW-1:0];
            live_wdata    = 1'b1;
            rsp_index_d   = HALF_W'(stack_rdata[IW-1:0]);
            rsp_version_d = stack_rdata[FW-1:IW];
          end else if (can_fresh) begin
            slots_used_d = slots_used_q + CW'(1);
            live_we      = 1'b1;
            live_waddr   = slots_used_q[IW-1:0];
            live_wdata   = 1'b1;
            rsp_index_d  = HALF_W'(slots_used_q);
          end else begin
            rsp_status_d = STATUS_FULL;
            rsp_index_d  = DEAD_INDEX;
          end
        end
        MODE_DESTROY: begin
          if (destroy_ok) begin
            live_we      = 1'b1;
            stack_we     = 1'b1;
            free_count_d = free_count_q + CW'(1);
          end else begin
            rsp_status_d = STATUS_BAD;
          end
        end
        MODE_CHECK: begin
          rsp_is_valid_d = (idx_q != DEAD_INDEX);
        end
        default: begin
          rsp_status_d = STATUS_OK;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      limit_q      <= LIMIT_RESET;
      free_count_q <= '0;
      slots_used_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      slots_used_q <= slots_used_d;
      rsp_valid_q  <= rsp_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture and response payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.mode;
      idx_q  <= req_i.handle_index;
      ver_q  <= req_i.handle_version;
    end
    rsp_index_q    <= rsp_index_d;
    rsp_version_q  <= rsp_version_d;
    rsp_status_q   <= rsp_status_d;
    rsp_is_valid_q <= rsp_is_valid_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.new_index   = rsp_index_q;
  assign rsp_o.new_version = rsp_version_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.is_valid    = rsp_is_valid_q;

endmodule

// ===== hdl/gha_checker.sv =====
`include "generational_handle_allocator_assert.svh"

module gha_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [gha_pkg::HALF_W-1:0]    rsp_new_index_i,
  input logic [gha_pkg::HALF_W-1:0]    rsp_new_version_i,
  input logic [gha_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic                          rsp_is_valid_i
);
  import gha_pkg::*;

  // One request at a time: the cycle after a transfer no request is taken.
  `GHA_ASSERT_NEXT(a_busy_after_accept, req_valid_i && req_ready_i, !req_ready_i)

  // A create that finds no slot returns the dead handle with version zero.
  `GHA_ASSERT(a_full_dead_handle, rsp_valid_i && rsp_status_i == STATUS_FULL, rsp_new_index_i == DEAD_INDEX && rsp_new_version_i == '0 && !rsp_is_valid_i)

  // A rejected destroy carries no handle and no check result.
  `GHA_ASSERT(a_bad_destroy_clean, rsp_valid_i && rsp_status_i == STATUS_BAD, rsp_new_index_i == '0 && rsp_new_version_i == '0 && !rsp_is_valid_i)

  // A positive check result comes only with an ok status and no handle.
  `GHA_ASSERT(a_check_clean, rsp_valid_i && rsp_is_valid_i, rsp_status_i == STATUS_OK && rsp_new_index_i == '0 && rsp_new_version_i == '0)

  // A stalled response stays put.
  `GHA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_new_index_i) && $stable(rsp_new_version_i) && $stable(rsp_status_i) && $stable(rsp_is_valid_i))

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_new_index_i   (rsp_o.new_index),
  .rsp_new_version_i (rsp_o.new_version),
  .rsp_status_i      (rsp_o.status),
  .rsp_is_valid_i    (rsp_o.is_valid)
);

// ===== sim/generational_handle_allocator_tb.sv =====
`timescale 1ns / 1ps

module generational_handle_allocator_tb;
  import gha_pkg::*;

  localparam int CAP          = 1024;
  localparam int CLK_PERIOD   = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_TAIL   = 4;
  localparam int MAX_PRINTED  = 40;

  // Mode code that the block ignores.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [HALF_W-1:0]   new_index;
    logic [HALF_W-1:0]   new_version;
    logic [STATUS_W-1:0] status;
    logic                is_valid;
  } alloc_rsp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  gha_req_if req_bus ();
  gha_rsp_if rsp_bus ();

  generational_handle_allocator #(
    .CAPACITY (CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Allocator state as the testbench sees it.
  logic [HALF_W-1:0]  slot_version [CAP];
  bit                 slot_alive [CAP];
  logic [9:0]         freed_slots [CAP];
  int                 freed_cnt;
  int                 fresh_cnt;
  logic [LIMIT_W-1:0] limit_reg;
  int                 alive_slots [$];

  // Responses still owed by the block, oldest first.
  alloc_rsp_t owed_rsp_q [$];

  int  mismatch_cnt;
  int  rsp_cnt;
  int  req_cnt;
  int  n_create, n_reuse, n_full, n_destroy, n_reject, n_check, n_ignored, n_cfg;

  bit  src_gaps_on;
  bit  sink_gaps_on;
  int  hold_req_cnt;
  int  quiet_cycles;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int usable_limit();
    return (int'(limit_reg) > CAP) ? CAP : int'(limit_reg);
  endfunction

  // Apply one request to the allocator state and return the response it owes.
  function automatic alloc_rsp_t alloc_outcome(input logic [MODE_W-1:0] m,
                                               input logic [HALF_W-1:0] hidx,
                                               input logic [HALF_W-1:0] hver);
    alloc_rsp_t r;
    int         slot;
    r = '0;
    case (m)
      MODE_CREATE: begin
        n_create++;
        if (freed_cnt > 0) begin
          freed_cnt--;
          slot = int'(freed_slots[freed_cnt]);
          slot_alive[slot] = 1'b1;
          alive_slots = {alive_slots, slot};
          r.new_index   = slot;
          r.new_version = slot_version[slot];
          n_reuse++;
        end else if (fresh_cnt < usable_limit()) begin
          slot = fresh_cnt;
          slot_version[slot] = '0;
          slot_alive[slot] = 1'b1;
          alive_slots = {alive_slots, slot};
          fresh_cnt++;
          r.new_index = slot;
        end else begin
          r.status    = STATUS_FULL;
          r.new_index = DEAD_INDEX;
          n_full++;
        end
      end
      MODE_DESTROY: begin
        n_destroy++;
        if (hidx >= fresh_cnt || hidx >= CAP || !slot_alive[hidx[9:0]] ||
            freed_cnt >= CAP) begin
          r.status = STATUS_BAD;
          n_reject++;
        end else begin
          slot = int'(hidx);
          slot_version[slot] = hver + 1'b1;
          slot_alive[slot] = 1'b0;
          freed_slots[freed_cnt] = slot[9:0];
          freed_cnt++;
          foreach (alive_slots[k]) begin
            if (alive_slots[k] == slot) begin
              alive_slots.delete(k);
              break;
            end
          end
        end
      end
      MODE_CHECK: begin
        n_check++;
        r.is_valid = (hidx != DEAD_INDEX);
      end
      default: begin
        n_ignored++;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [HALF_W-1:0] got,
                                 input logic [HALF_W-1:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) begin
      $display("mismatch: response %0d %s got %0h want %0h", rsp_cnt, what, got, want);
    end
  endtask

  // Offer one request and wait for its transfer; the response owed is
  // computed at the moment of the transfer.
  task automatic send_req(input logic [MODE_W-1:0] m, input logic [HALF_W-1:0] hidx,
                          input logic [HALF_W-1:0] hver);
    int         gap;
    alloc_rsp_t owed;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid          <= 1'b1;
    req_bus.mode           <= m;
    req_bus.handle_index   <= hidx;
    req_bus.handle_version <= hver;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    owed = alloc_outcome(m, hidx, hver);
    owed_rsp_q = {owed_rsp_q, owed};
    req_cnt++;
  endtask

  // Stop offering and wait until every owed response has arrived.
  task automatic drain_pipeline();
    req_bus.valid <= 1'b0;
    while (owed_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_reg = value;
    n_cfg++;
  endtask

  // One request drawn from a mix that is mostly well-formed handle traffic.
  task automatic send_mixed(input int create_pct, input int destroy_pct);
    int                roll;
    int                slot;
    logic [HALF_W-1:0] hidx;
    logic [HALF_W-1:0] hver;
    roll = $urandom_range(0, 99);
    hidx = $urandom;
    hver = $urandom;
    if (roll < create_pct || (roll < create_pct + destroy_pct && alive_slots.size() == 0)) begin
      send_req(MODE_CREATE, hidx, hver);
    end else if (roll < create_pct + destroy_pct) begin
      // Destroy a live handle, usually with the version it was handed out with.
      slot = alive_slots[$urandom_range(0, alive_slots.size() - 1)];
      if ($urandom_range(0, 3) != 0) begin
        hver = slot_version[slot];
      end
      send_req(MODE_DESTROY, slot, hver);
    end else begin
      case ($urandom_range(0, 9))
        0: send_req(MODE_DESTROY, fresh_cnt, hver);
        1: send_req(MODE_DESTROY, hidx, hver);
        2: begin
          if (freed_cnt > 0) begin
            hidx = HALF_W'(freed_slots[$urandom_range(0, freed_cnt - 1)]);
          end
          send_req(MODE_DESTROY, hidx, hver);
        end
        3: send_req(MODE_DESTROY, DEAD_INDEX, hver);
        4: send_req(MODE_CHECK, DEAD_INDEX, hver);
        5: send_req(MODE_CHECK, hidx, hver);
        6, 7: begin
          if (alive_slots.size() != 0) begin
            hidx = alive_slots[$urandom_range(0, alive_slots.size() - 1)];
          end
          send_req(MODE_CHECK, hidx, hver);
        end
        default: send_req(MODE_UNUSED, hidx, hver);
      endcase
    end
  endtask

  task automatic run_mix(input int n_items, input int create_pct, input int destroy_pct);
    repeat (n_items) send_mixed(create_pct, destroy_pct);
  endtask

  // Idle handle values and an ignored mode right after reset.
  task automatic test_after_reset();
    send_req(MODE_CHECK, DEAD_INDEX, '0);
    send_req(MODE_CHECK, '0, '1);
    send_req(MODE_DESTROY, '0, '0);
    send_req(MODE_UNUSED, '1, '1);
  endtask

  // Fresh slots, version wrap, double and out-of-range destroys, LIFO reuse.
  task automatic test_lifecycle();
    send_req(MODE_CREATE, '0, '0);
    send_req(MODE_CREATE, '1, '1);
    send_req(MODE_DESTROY, 32'd1, 32'hFFFF_FFFF);
    send_req(MODE_DESTROY, 32'd1, 32'd0);
    send_req(MODE_DESTROY, 32'd2, 32'd0);
    send_req(MODE_DESTROY, DEAD_INDEX, 32'd0);
    send_req(MODE_DESTROY, 32'd0, 32'h7FFF_FFFE);
    send_req(MODE_CREATE, '0, '0);
    send_req(MODE_CREATE, '0, '0);
    send_req(MODE_CHECK, 32'hFFFF_FFFE, '0);
  endtask

  // With no fresh slots allowed, freed slots are still handed out.
  task automatic test_limit_zero();
    set_limit('0);
    send_req(MODE_DESTROY, 32'd0, 32'h8000_0000);
    send_req(MODE_CREATE, '0, '0);
    send_req(MODE_CREATE, '0, '0);
  endtask

  // A limit under the number of slots already used acts as full for fresh slots.
  task automatic test_limit_below_used();
    set_limit(11'd1);
    send_req(MODE_CREATE, '0, '0);
    send_req(MODE_DESTROY, 32'd1, 32'd5);
    send_req(MODE_CREATE, '0, '0);
    send_req(MODE_CREATE, '0, '0);
  endtask

  task automatic test_small_limits();
    int limits [8] = '{1, 2, 0, 3, 5, 8, 16, 40};
    foreach (limits[i]) begin
      set_limit(LIMIT_W'(limits[i]));
      src_gaps_on  = (i % 3 != 0);
      sink_gaps_on = (i % 4 != 1);
      run_mix(45, 45, 35);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    drain_pipeline();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    hold_req_cnt++;
    run_mix(40, 50, 30);
    drain_pipeline();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // A limit above the capacity is capped; heavy create traffic takes many
  // fresh slots under it.
  task automatic test_limit_over_capacity();
    set_limit('1);
    run_mix(300, 80, 10);
  endtask

  task automatic test_wide_limit();
    set_limit(LIMIT_RESET);
    run_mix(120, 40, 40);
    set_limit(11'd300);
    run_mix(80, 45, 35);
  endtask

  // Response ready: random gaps, plus a long hold-off when one is requested.
  int hold_seen;
  int hold_left;
  int sink_gap_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES - 1;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (sink_gap_left > 0) begin
      sink_gap_left--;
      rsp_bus.ready <= 1'b0;
    end else if (sink_gaps_on && $urandom_range(0, 99) < 25) begin
      sink_gap_left = pick_gap() - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Compare each response transfer with the oldest owed response.
  always @(posedge clk_i) begin : check_rsp
    alloc_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      rsp_cnt++;
      if (owed_rsp_q.size() == 0) begin
        report_mismatch("arrived with nothing owed, new_index", rsp_bus.new_index, '0);
      end else begin
        want = owed_rsp_q.pop_front();
        if (rsp_bus.new_index !== want.new_index) begin
          report_mismatch("new_index", rsp_bus.new_index, want.new_index);
        end
        if (rsp_bus.new_version !== want.new_version) begin
          report_mismatch("new_version", rsp_bus.new_version, want.new_version);
        end
        if (rsp_bus.status !== want.status) begin
          report_mismatch("status", HALF_W'(rsp_bus.status), HALF_W'(want.status));
        end
        if (rsp_bus.is_valid !== want.is_valid) begin
          report_mismatch("is_valid", HALF_W'(rsp_bus.is_valid), HALF_W'(want.is_valid));
        end
      end
    end
  end

  // End the run when nothing has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d responses still owed", owed_rsp_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    req_bus.valid          = 1'b0;
    req_bus.mode           = MODE_CREATE;
    req_bus.handle_index   = '0;
    req_bus.handle_version = '0;
    freed_cnt              = 0;
    fresh_cnt              = 0;
    limit_reg              = LIMIT_RESET;
    src_gaps_on            = 1'b1;
    sink_gaps_on           = 1'b1;
    foreach (slot_alive[i]) slot_alive[i] = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_lifecycle();
    test_limit_zero();
    test_limit_below_used();
    test_small_limits();
    test_backpressure();
    test_limit_over_capacity();
    test_wide_limit();

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    if (owed_rsp_q.size() != 0) begin
      report_mismatch("owed responses left at the end", HALF_W'(owed_rsp_q.size()), '0);
    end

    $display("summary: %0d requests, %0d creates (%0d reused, %0d full),",
             req_cnt, n_create, n_reuse, n_full);
    $display("summary: %0d destroys (%0d rejected), %0d checks, %0d ignored, %0d limit writes",
             n_destroy, n_reject, n_check, n_ignored, n_cfg);
    $display("summary: %0d slots used, %0d mismatches", fresh_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
